// ===== hw/rtl/srsb_pkg.sv =====
// Package of shared types and constants for the status register and stack bank.
`timescale 1ns / 1ps
`default_nettype none

package srsb_pkg;

  // Status register bit positions.
  localparam int unsigned SrBitT1   = 15;
  localparam int unsigned SrBitT0   = 14;
  localparam int unsigned SrBitS    = 13;
  localparam int unsigned SrBitM    = 12;
  localparam int unsigned SrMaskLsb = 8;

  // Interrupt level that cannot be masked.
  localparam logic [2:0] LevelNmi = 3'd7;

  // Reset value of the interrupt mask.
  localparam logic [2:0] MaskReset = 3'd7;

  // Command codes.
  typedef enum logic [2:0] {
    CMD_WR_SR  = 3'd0,
    CMD_WR_CCR = 3'd1,
    CMD_RD_SR  = 3'd2,
    CMD_WR_SP  = 3'd3,
    CMD_RD_SP  = 3'd4,
    CMD_SET_IPL = 3'd5
  } cmd_e;

  // Processor model class codes.
  typedef enum logic [1:0] {
    MODEL_68000 = 2'd0,
    MODEL_68010 = 2'd1,
    MODEL_68020 = 2'd2
  } model_e;

  typedef logic [1:0] model_class_t;

  // One request item.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] value;
  } req_t;

  // One response item.
  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_pending;
    logic        supervisor_mode;
    logic        master_mode;
    logic        trace_enabled;
  } rsp_t;

  // Internal state seen by the top level.
  typedef struct packed {
    logic        supervisor;
    logic        master;
    logic [2:0]  mask;
    logic [31:0] active_sp;
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/srsb_stream_if.sv =====
// Valid/ready channel interface carrying one payload item per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface srsb_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/srsb_stage.sv =====
// Single register stage with valid/ready flow control.
`timescale 1ns / 1ps
`default_nettype none

module srsb_stage #(
  parameter type T = logic
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  input  T          data_i,
  output logic      ready_o,
  output logic      valid_o,
  output T          data_o,
  input  wire logic ready_i
);

  logic valid_q;
  T     data_q;

  // The stage takes a new item when empty or when its item leaves this cycle.
  assign ready_o = !valid_q || ready_i;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/srsb_core.sv =====
// Status register fields, stack pointer banks and the per-command update logic.
`timescale 1ns / 1ps
`default_nettype none

module srsb_core (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  srsb_pkg::model_class_t      cfg_data_i,
  input  wire logic                   step_i,
  input  srsb_pkg::req_t              req_i,
  output srsb_pkg::rsp_t              rsp_o,
  output srsb_pkg::status_t           status_o
);

  srsb_pkg::model_class_t model_q;
  logic        t1_q, t1_d;
  logic        t0_q, t0_d;
  logic        s_q, s_d;
  logic        m_q, m_d;
  logic [2:0]  mask_q, mask_d;
  logic [4:0]  flags_q, flags_d;
  logic [31:0] active_q, active_d;
  logic [31:0] usp_q, usp_d;
  logic [31:0] isp_q, isp_d;
  logic [31:0] msp_q, msp_d;
  logic [2:0]  level_q, level_d;

  logic        wide_model;
  logic        new_s;
  logic        new_m;
  logic        bank_change;
  logic [15:0] sr_read;
  logic [31:0] read_data;

  // Class 2 and above may write t0 and m.
  assign wide_model = (model_q >= srsb_pkg::model_class_t'(srsb_pkg::MODEL_68020));

  // Status register as read, with unused bits zero.
  assign sr_read = {t1_q, t0_q, s_q, m_q, 1'b0, mask_q, 3'b000, flags_q};

  // Next state and read data for the item in the input register.
  always_comb begin
    t1_d        = t1_q;
    t0_d        = t0_q;
    s_d         = s_q;
    m_d         = m_q;
    mask_d      = mask_q;
    flags_d     = flags_q;
    active_d    = active_q;
    usp_d       = usp_q;
    isp_d       = isp_q;
    msp_d       = msp_q;
    level_d     = level_q;
    read_data   = '0;
    new_s       = req_i.value[srsb_pkg::SrBitS];
    new_m       = wide_model ? req_i.value[srsb_pkg::SrBitM] : m_q;
    bank_change = (new_s != s_q) || (new_m != m_q);
    unique case (srsb_pkg::cmd_e'(req_i.cmd))
      srsb_pkg::CMD_WR_SR: begin
        t1_d    = req_i.value[srsb_pkg::SrBitT1];
        mask_d  = req_i.value[srsb_pkg::SrMaskLsb +: 3];
        flags_d = req_i.value[4:0];
        if (wide_model) begin
          t0_d = req_i.value[srsb_pkg::SrBitT0];
        end
        if (bank_change) begin
          // Save the active pointer to the bank being left.
          if (!s_q) begin
            usp_d = active_q;
          end else if (!m_q) begin
            isp_d = active_q;
          end else begin
            msp_d = active_q;
          end
          s_d = new_s;
          m_d = new_m;
          // Load the pointer of the bank being entered.
          if (!new_s) begin
            active_d = usp_d;
          end else if (!new_m) begin
            active_d = isp_d;
          end else begin
            active_d = msp_d;
          end
        end
      end
      srsb_pkg::CMD_WR_CCR:  flags_d   = req_i.value[4:0];
      srsb_pkg::CMD_RD_SR:   read_data = {16'h0000, sr_read};
      srsb_pkg::CMD_WR_SP:   active_d  = req_i.value;
      srsb_pkg::CMD_RD_SP:   read_data = active_q;
      srsb_pkg::CMD_SET_IPL: level_d   = req_i.value[2:0];
      default: begin
        // Undefined commands change nothing.
      end
    endcase
  end

  // Response reflects the state after the step.
  always_comb begin
    rsp_o.read_data       = read_data;
    rsp_o.irq_pending     = (level_d > mask_d) || (level_d == srsb_pkg::LevelNmi);
    rsp_o.supervisor_mode = s_d;
    rsp_o.master_mode     = m_d;
    rsp_o.trace_enabled   = t1_d;
  end

  // Model class register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q <= srsb_pkg::model_class_t'(srsb_pkg::MODEL_68000);
    end else if (cfg_we_i) begin
      model_q <= cfg_data_i;
    end
  end

  // Architectural state, updated once per processed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q     <= 1'b0;
      t0_q     <= 1'b0;
      s_q      <= 1'b1;
      m_q      <= 1'b0;
      mask_q   <= srsb_pkg::MaskReset;
      flags_q  <= '0;
      active_q <= '0;
      usp_q    <= '0;
      isp_q    <= '0;
      msp_q    <= '0;
      level_q  <= '0;
    end else if (step_i) begin
      t1_q     <= t1_d;
      t0_q     <= t0_d;
      s_q      <= s_d;
      m_q      <= m_d;
      mask_q   <= mask_d;
      flags_q  <= flags_d;
      active_q <= active_d;
      usp_q    <= usp_d;
      isp_q    <= isp_d;
      msp_q    <= msp_d;
      level_q  <= level_d;
    end
  end

  assign status_o = '{supervisor: s_q, master: m_q, mask: mask_q, active_sp: active_q};

endmodule

`default_nettype wire

// ===== hw/rtl/status_register_stack_bank.sv =====
// Top level of the status register and stack pointer bank.
//
//   channel  direction  payload                               transfer when
//   cfg_i    in         model class (2 bits)                  cfg_i.valid && cfg_i.ready
//   req_i    in         cmd (3), value (32)                   req_i.valid && req_i.ready
//   rsp_o    out        read_data, irq and mode bits          rsp_o.valid && rsp_o.ready
//
// One item per cycle while responses are taken; a request passes through the
// input register, then the result register after the update logic.
// The state registers commit when an item moves from the input register to the
// result register. A stalled response holds that move; the input register takes
// one more item only while it is empty. Reset restores the supervisor-mode state
// with mask 7. The configuration channel is always ready.
`timescale 1ns / 1ps
`default_nettype none

module status_register_stack_bank (
  input wire logic clk_i,
  input wire logic rst_ni,
  srsb_stream_if.sink   cfg_i,
  srsb_stream_if.sink   req_i,
  srsb_stream_if.source rsp_o
);

  logic              in_valid;
  srsb_pkg::req_t    in_data;
  logic              in_ready;
  logic              out_ready;
  logic              step;
  srsb_pkg::rsp_t    rsp_next;
  srsb_pkg::status_t status;

  assign cfg_i.ready = 1'b1;

  // Input register.
  srsb_stage #(.T(srsb_pkg::req_t)) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .data_i  (req_i.data),
    .ready_o (req_i.ready),
    .valid_o (in_valid),
    .data_o  (in_data),
    .ready_i (in_ready)
  );

  // An item is processed when it moves into the result register.
  assign in_ready = out_ready;
  assign step     = in_valid && out_ready;

  srsb_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid && cfg_i.ready),
    .cfg_data_i (cfg_i.data),
    .step_i     (step),
    .req_i      (in_data),
    .rsp_o      (rsp_next),
    .status_o   (status)
  );

  // Result register.
  srsb_stage #(.T(srsb_pkg::rsp_t)) u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .data_i  (rsp_next),
    .ready_o (out_ready),
    .valid_o (rsp_o.valid),
    .data_o  (rsp_o.data),
    .ready_i (rsp_o.ready)
  );

  // A processed item always lands in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) step |=> rsp_o.valid)
    else $error("processed item did not reach the result register");

  // A stack pointer write becomes the active pointer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (in_data.cmd == srsb_pkg::CMD_WR_SP) |=> status.active_sp == $past(in_data.value))
    else $error("stack pointer write lost");

  // The input stalls only behind a response that is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> rsp_o.valid && !rsp_o.ready)
    else $error("input stalled with no waiting response");

  // Only read commands return data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (in_data.cmd != srsb_pkg::CMD_RD_SR) && (in_data.cmd != srsb_pkg::CMD_RD_SP)
    |=> rsp_o.data.read_data == '0)
    else $error("non-read command returned data");

  // Reported mode bits follow the committed state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> (rsp_o.data.supervisor_mode == status.supervisor)
      && (rsp_o.data.master_mode == status.master))
    else $error("response mode bits differ from state");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the status register and stack pointer bank.
`timescale 1ns / 1ps

module testbench;

  // Command codes outside the defined set, and the model class above the top one.
  localparam logic [2:0]             CmdSpareLo      = 3'd6;
  localparam logic [2:0]             CmdSpareHi      = 3'd7;
  localparam srsb_pkg::model_class_t ModelClassSpare = 2'd3;

  localparam int unsigned ResetCycles  = 7;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned PhaseItems   = 235;
  localparam int unsigned CycleLimit   = 400000;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_e;

  typedef struct {
    row_kind_e              kind;
    srsb_pkg::model_class_t model_class;
    srsb_pkg::req_t         req;
    bit                     typed;
    srsb_pkg::rsp_t         want;
  } stim_row_t;

  typedef struct {
    srsb_pkg::model_class_t model_class;
    int unsigned            send_idle_pct;
    int unsigned            recv_idle_pct;
    bit                     hold_off;
  } phase_t;

  logic clk_i;
  logic rst_ni;

  srsb_stream_if #(.T(srsb_pkg::model_class_t)) cfg_if ();
  srsb_stream_if #(.T(srsb_pkg::req_t))         req_if ();
  srsb_stream_if #(.T(srsb_pkg::rsp_t))         rsp_if ();

  status_register_stack_bank i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if.sink),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // Predicted architectural state.
  srsb_pkg::model_class_t core_class;
  logic         sr_t1, sr_t0, sr_s, sr_m;
  logic [2:0]   sr_mask;
  logic [4:0]   sr_flags;
  logic [2:0]   ext_level;
  logic [31:0]  active_sp, user_sp, irq_sp, master_sp;

  srsb_pkg::rsp_t status_expect_q[$];
  stim_row_t      directed_rows[$];
  bit             failed = 1'b0;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  int unsigned    cycle_count = 0;
  bit             hold_request;
  bit             rsp_hold;

  // Clock generation.
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Advances the predicted state by one request and returns the response it causes.
  function automatic srsb_pkg::rsp_t step_status(input srsb_pkg::req_t r);
    srsb_pkg::rsp_t res;
    logic           new_s;
    logic           new_m;
    logic [15:0]    sr_word;
    res.read_data = '0;
    case (r.cmd)
      srsb_pkg::CMD_WR_SR: begin
        sr_word  = r.value[15:0];
        new_s    = sr_word[srsb_pkg::SrBitS];
        new_m    = sr_m;
        sr_mask  = sr_word[srsb_pkg::SrMaskLsb +: 3];
        sr_t1    = sr_word[srsb_pkg::SrBitT1];
        sr_flags = sr_word[4:0];
        if (core_class >= srsb_pkg::MODEL_68020) begin
          sr_t0 = sr_word[srsb_pkg::SrBitT0];
          new_m = sr_word[srsb_pkg::SrBitM];
        end
        // A change of s or m saves the active pointer and loads the new bank.
        if (new_s != sr_s || new_m != sr_m) begin
          if (!sr_s)      user_sp   = active_sp;
          else if (!sr_m) irq_sp    = active_sp;
          else            master_sp = active_sp;
          sr_s = new_s;
          sr_m = new_m;
          if (!sr_s)      active_sp = user_sp;
          else if (!sr_m) active_sp = irq_sp;
          else            active_sp = master_sp;
        end
      end
      srsb_pkg::CMD_WR_CCR:  sr_flags = r.value[4:0];
      srsb_pkg::CMD_RD_SR:   res.read_data = {16'h0, sr_t1, sr_t0, sr_s, sr_m, 1'b0, sr_mask,
                                              3'b000, sr_flags};
      srsb_pkg::CMD_WR_SP:   active_sp = r.value;
      srsb_pkg::CMD_RD_SP:   res.read_data = active_sp;
      srsb_pkg::CMD_SET_IPL: ext_level = r.value[2:0];
      default: ;
    endcase
    res.irq_pending     = (ext_level > sr_mask) || (ext_level == srsb_pkg::LevelNmi);
    res.supervisor_mode = sr_s;
    res.master_mode     = sr_m;
    res.trace_enabled   = sr_t1;
    return res;
  endfunction

  // Random request, weighted towards SR writes and reads so that bank switches are frequent.
  function automatic srsb_pkg::req_t random_request();
    srsb_pkg::req_t r;
    int unsigned    pick;
    pick    = $urandom_range(99);
    r.value = $urandom();
    if (pick < 25)      r.cmd = srsb_pkg::CMD_WR_SR;
    else if (pick < 35) r.cmd = srsb_pkg::CMD_WR_CCR;
    else if (pick < 55) r.cmd = srsb_pkg::CMD_RD_SR;
    else if (pick < 70) r.cmd = srsb_pkg::CMD_WR_SP;
    else if (pick < 85) r.cmd = srsb_pkg::CMD_RD_SP;
    else if (pick < 97) r.cmd = srsb_pkg::CMD_SET_IPL;
    else                r.cmd = 3'($urandom_range(CmdSpareHi, CmdSpareLo));
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Stimulus table rows.
  function automatic void add_cfg(input srsb_pkg::model_class_t mc);
    stim_row_t row;
    row = '{kind: ROW_CFG, model_class: mc, req: '0, typed: 1'b0, want: '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_req(input logic [2:0] cmd, input logic [31:0] value);
    stim_row_t row;
    row = '{kind: ROW_REQ, model_class: '0, req: '{cmd: cmd, value: value}, typed: 1'b0,
            want: '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_typed(input logic [2:0] cmd, input logic [31:0] value,
                                    input srsb_pkg::rsp_t want);
    stim_row_t row;
    row = '{kind: ROW_REQ, model_class: '0, req: '{cmd: cmd, value: value}, typed: 1'b1,
            want: want};
    directed_rows.push_back(row);
  endfunction

  // Offers one request, with random gaps, and records its expectation on transfer.
  // Entered and left at a falling edge.
  task automatic send_request(input srsb_pkg::req_t r, input bit typed,
                              input srsb_pkg::rsp_t want);
    srsb_pkg::rsp_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predicted = step_status(r);
    status_expect_q.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  // Writes the model class once the block has gone idle.
  task automatic write_model_class(input srsb_pkg::model_class_t mc);
    req_if.valid <= 1'b0;
    while (status_expect_q.size() != 0) @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= mc;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    core_class = mc;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Response ready with random stalls, held low during the hold-off.
  always @(negedge clk_i) begin
    rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Long receiver hold-off so that the block fills and stalls its input.
  initial begin
    rsp_hold = 1'b0;
    wait (hold_request);
    @(posedge clk_i);
    rsp_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rsp_hold = 1'b0;
  end

  // Response checking against the oldest expectation.
  always @(posedge clk_i) begin
    srsb_pkg::rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (status_expect_q.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual %h", $realtime, rsp_if.data);
        failed = 1'b1;
      end else begin
        want = status_expect_q.pop_front();
        check_field("read_data", want.read_data, rsp_if.data.read_data);
        check_field("irq_pending", 32'(want.irq_pending), 32'(rsp_if.data.irq_pending));
        check_field("supervisor_mode", 32'(want.supervisor_mode),
                    32'(rsp_if.data.supervisor_mode));
        check_field("master_mode", 32'(want.master_mode), 32'(rsp_if.data.master_mode));
        check_field("trace_enabled", 32'(want.trace_enabled), 32'(rsp_if.data.trace_enabled));
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    phase_t phases[6];
    phases[0] = '{model_class: srsb_pkg::MODEL_68000, send_idle_pct: 10, recv_idle_pct: 57,
                  hold_off: 1'b0};
    phases[1] = '{model_class: srsb_pkg::MODEL_68020, send_idle_pct: 10, recv_idle_pct: 57,
                  hold_off: 1'b0};
    phases[2] = '{model_class: srsb_pkg::MODEL_68010, send_idle_pct: 57, recv_idle_pct: 10,
                  hold_off: 1'b0};
    phases[3] = '{model_class: ModelClassSpare,       send_idle_pct: 57, recv_idle_pct: 10,
                  hold_off: 1'b0};
    phases[4] = '{model_class: srsb_pkg::MODEL_68020, send_idle_pct: 0,  recv_idle_pct: 0,
                  hold_off: 1'b1};
    phases[5] = '{model_class: srsb_pkg::MODEL_68000, send_idle_pct: 0,  recv_idle_pct: 0,
                  hold_off: 1'b0};

    // Known values on the driven inputs from the start.
    rst_ni        = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    req_if.valid  = 1'b0;
    req_if.data   = '0;
    hold_request  = 1'b0;
    send_idle_pct = phases[0].send_idle_pct;
    recv_idle_pct = phases[0].recv_idle_pct;

    // Predicted state after reset.
    core_class = srsb_pkg::MODEL_68000;
    sr_t1      = 1'b0;
    sr_t0      = 1'b0;
    sr_s       = 1'b1;
    sr_m       = 1'b0;
    sr_mask    = srsb_pkg::MaskReset;
    sr_flags   = '0;
    ext_level  = '0;
    active_sp  = '0;
    user_sp    = '0;
    irq_sp     = '0;
    master_sp  = '0;

    // Directed table: reset values, field extremes, every command and bank transition.
    add_typed(srsb_pkg::CMD_RD_SR, 32'h0, '{read_data: 32'h0000_2700, irq_pending: 1'b0,
              supervisor_mode: 1'b1, master_mode: 1'b0, trace_enabled: 1'b0});
    add_typed(srsb_pkg::CMD_RD_SP, 32'h0, '{read_data: 32'h0, irq_pending: 1'b0,
              supervisor_mode: 1'b1, master_mode: 1'b0, trace_enabled: 1'b0});
    add_typed(srsb_pkg::CMD_SET_IPL, 32'hFFFF_FFFF, '{read_data: 32'h0, irq_pending: 1'b1,
              supervisor_mode: 1'b1, master_mode: 1'b0, trace_enabled: 1'b0});
    add_req(srsb_pkg::CMD_WR_SP, 32'hFFFF_FFFF);
    add_req(srsb_pkg::CMD_WR_SR, 32'hFFFF_FFFF);
    add_req(srsb_pkg::CMD_RD_SR, 32'h0);
    add_req(srsb_pkg::CMD_WR_SR, 32'h0000_0000);
    add_req(srsb_pkg::CMD_WR_SP, 32'h1234_5678);
    add_req(srsb_pkg::CMD_SET_IPL, 32'h0);
    add_req(srsb_pkg::CMD_SET_IPL, 32'hFFFF_FFF9);
    add_req(srsb_pkg::CMD_WR_CCR, 32'hFFFF_FFE0);
    add_req(srsb_pkg::CMD_WR_CCR, 32'h0000_001F);
    add_req(CmdSpareLo, 32'hFFFF_FFFF);
    add_req(CmdSpareHi, 32'hFFFF_FFFF);
    add_cfg(srsb_pkg::MODEL_68020);
    add_req(srsb_pkg::CMD_WR_SR, 32'h0000_3000);
    add_req(srsb_pkg::CMD_WR_SP, 32'hDEAD_BEEF);
    add_req(srsb_pkg::CMD_WR_SR, 32'h0000_2000);
    add_req(srsb_pkg::CMD_RD_SP, 32'h0);
    // User mode with m set: m is stored and the user pointer becomes active.
    add_req(srsb_pkg::CMD_WR_SR, 32'h0000_1000);
    add_req(srsb_pkg::CMD_RD_SP, 32'h0);
    add_req(srsb_pkg::CMD_WR_SR, 32'h0000_F7FF);
    add_req(srsb_pkg::CMD_RD_SR, 32'h0);
    add_cfg(ModelClassSpare);
    add_req(srsb_pkg::CMD_WR_SR, 32'h0000_4000);
    add_req(srsb_pkg::CMD_RD_SR, 32'h0);
    add_cfg(srsb_pkg::MODEL_68010);
    add_req(srsb_pkg::CMD_WR_SR, 32'h0000_3000);
    add_req(srsb_pkg::CMD_RD_SR, 32'h0);

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_model_class(directed_rows[i].model_class);
      end else begin
        send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random part, one phase per setting and idle profile.
    foreach (phases[p]) begin
      write_model_class(phases[p].model_class);
      send_idle_pct = phases[p].send_idle_pct;
      recv_idle_pct = phases[p].recv_idle_pct;
      if (phases[p].hold_off) hold_request = 1'b1;
      repeat (PhaseItems) send_request(random_request(), 1'b0, '0);
    end

    // Drain and let the pipeline settle before the verdict.
    req_if.valid <= 1'b0;
    while (status_expect_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
